/* hdl/urc_pkg.sv */
// ----------------------------------------------------------------------------
// urc_pkg
// Shared types, codes and reset values for the ultrasonic ranging controller.
// ----------------------------------------------------------------------------
`default_nettype none

package urc_pkg;

   // measurement counter width default
   localparam int URC_COUNT_WIDTH = 16;

   // fixed field widths
   localparam int URC_DIVISOR_WIDTH = 8;
   localparam int URC_DIST_WIDTH    = 16;
   localparam int URC_US_WIDTH      = 24;
   localparam int URC_CSR_IDX_WIDTH = 3;
   localparam int URC_CSR_DAT_WIDTH = 24;
   localparam int URC_REQ_WIDTH     = 8;
   localparam int URC_RSP_WIDTH     = 24;

   // register indexes
   localparam logic [URC_CSR_IDX_WIDTH-1:0] REG_TRIGGER_LEAD  = 3'd0;
   localparam logic [URC_CSR_IDX_WIDTH-1:0] REG_TRIGGER_WIDTH = 3'd1;
   localparam logic [URC_CSR_IDX_WIDTH-1:0] REG_PRESCALE      = 3'd2;
   localparam logic [URC_CSR_IDX_WIDTH-1:0] REG_WAIT_LIMIT    = 3'd3;
   localparam logic [URC_CSR_IDX_WIDTH-1:0] REG_MAX_COUNT     = 3'd4;
   localparam logic [URC_CSR_IDX_WIDTH-1:0] REG_DIVISOR       = 3'd5;
   localparam logic [URC_CSR_IDX_WIDTH-1:0] REG_PERIOD        = 3'd6;

   // register reset values
   localparam logic [7:0]  RST_TRIGGER_LEAD  = 8'd5;
   localparam logic [7:0]  RST_TRIGGER_WIDTH = 8'd10;
   localparam logic [7:0]  RST_PRESCALE      = 8'd10;
   localparam logic [15:0] RST_WAIT_LIMIT    = 16'd1000;
   localparam logic [15:0] RST_MAX_COUNT     = 16'd22857;
   localparam logic [7:0]  RST_DIVISOR       = 8'd58;
   localparam logic [23:0] RST_PERIOD        = 24'd500000;

   // status codes
   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_NO_ECHO  = 2'd1,
      STATUS_TOO_LONG = 2'd2
   } status_type;

   // ranging phase
   typedef enum logic [4:0] {
      PH_LEAD    = 5'b00001,
      PH_PULSE   = 5'b00010,
      PH_WAIT    = 5'b00100,
      PH_MEASURE = 5'b01000,
      PH_IDLE    = 5'b10000
   } phase_type;

   // beat sequencer
   typedef enum logic [3:0] {
      SEQ_READY = 4'b0001,
      SEQ_EVAL  = 4'b0010,
      SEQ_DIV   = 4'b0100,
      SEQ_DONE  = 4'b1000
   } seq_type;

endpackage

`default_nettype wire

/* hdl/urc_divider.sv */
// ----------------------------------------------------------------------------
// urc_divider
// Restoring divider, one quotient bit per cycle, echo count by divisor.
// ----------------------------------------------------------------------------
`default_nettype none

module urc_divider #(
   parameter int COUNT_WIDTH = urc_pkg::URC_COUNT_WIDTH
) (
   input  wire logic                                     clock,
   input  wire logic                                     reset,
   input  wire logic                                     start,
   output logic                                          done,
   input  wire logic [COUNT_WIDTH-1:0]                   dividend,
   input  wire logic [urc_pkg::URC_DIVISOR_WIDTH-1:0]    divisor,
   output logic [COUNT_WIDTH-1:0]                        quotient
);
   import urc_pkg::*;

   localparam int CNT_W = $clog2(COUNT_WIDTH + 1);

   logic [CNT_W-1:0]             cnt_ff, cnt_in;
   logic                         done_ff, done_in;
   logic [COUNT_WIDTH-1:0]       quot_ff, quot_in;
   logic [URC_DIVISOR_WIDTH-1:0] rem_ff, rem_in;
   logic [URC_DIVISOR_WIDTH-1:0] div_ff, div_in;
   logic [URC_DIVISOR_WIDTH:0]   shifted;
   logic [URC_DIVISOR_WIDTH:0]   diff;
   logic                         fits;

   assign shifted = {rem_ff, quot_ff[COUNT_WIDTH-1]};
   assign diff    = shifted - {1'b0, div_ff};
   assign fits    = shifted >= {1'b0, div_ff};

   always_comb begin
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      quot_in = quot_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      if (start) begin
         cnt_in  = CNT_W'(COUNT_WIDTH);
         quot_in = dividend;
         rem_in  = '0;
         div_in  = divisor;
      end else if (cnt_ff != '0) begin
         cnt_in  = cnt_ff - CNT_W'(1);
         quot_in = {quot_ff[COUNT_WIDTH-2:0], fits};
         rem_in  = fits ? diff[URC_DIVISOR_WIDTH-1:0] : shifted[URC_DIVISOR_WIDTH-1:0];
         done_in = (cnt_ff == CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      div_ff  <= div_in;
   end

   assign done     = done_ff;
   assign quotient = quot_ff;

endmodule

`default_nettype wire

/* hdl/ultrasonic_ranging_controller.sv */
// ----------------------------------------------------------------------------
// ultrasonic_ranging_controller
// Trigger / echo ranging sequencer, one request beat per microsecond tick.
// ----------------------------------------------------------------------------
// sequence: request beat registered, tick evaluated, then the response registered
//   once the output is free; on an echo fall the serial divider (one bit per
//   cycle) runs before the response. No new beat is taken until it is registered.
// reset: synchronous, loads register defaults and restarts in the lead phase
// ----------------------------------------------------------------------------
`default_nettype none

module ultrasonic_ranging_controller #(
   parameter int COUNT_WIDTH = urc_pkg::URC_COUNT_WIDTH
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   // request: [0] echo_level, [7:1] zero
   input  wire logic                                   req_tvalid,
   output logic                                        req_tready,
   input  wire logic [urc_pkg::URC_REQ_WIDTH-1:0]      req_tdata,
   // response: [0] trigger_level, [1] result_valid, [3:2] status,
   //           [19:4] distance, [23:20] zero
   output logic                                        rsp_tvalid,
   input  wire logic                                   rsp_tready,
   output logic [urc_pkg::URC_RSP_WIDTH-1:0]           rsp_tdata,
   // register write channel
   input  wire logic                                   csr_valid,
   output logic                                        csr_ready,
   input  wire logic [urc_pkg::URC_CSR_IDX_WIDTH-1:0]  csr_index,
   input  wire logic [urc_pkg::URC_CSR_DAT_WIDTH-1:0]  csr_data
);
   import urc_pkg::*;

   localparam int CMP_W = COUNT_WIDTH + 16;

   // prescaler step result
   typedef struct packed {
      logic       tick;
      logic [7:0] count;
   } presc_type;

   function automatic logic [7:0] at_least_one8(input logic [7:0] v);
      return (v == 8'd0) ? 8'd1 : v;
   endfunction

   function automatic presc_type presc_step(input logic [7:0] cnt, input logic [7:0] lim);
      presc_type  r;
      logic [7:0] nxt;
      nxt = cnt + 8'd1;
      if (nxt >= at_least_one8(lim) || nxt == 8'd0) begin
         r.tick  = 1'b1;
         r.count = 8'd0;
      end else begin
         r.tick  = 1'b0;
         r.count = nxt;
      end
      return r;
   endfunction

   // configuration registers
   logic [7:0]  lead_ff, lead_in;
   logic [7:0]  width_ff, width_in;
   logic [7:0]  presc_ff, presc_in;
   logic [15:0] wait_lim_ff, wait_lim_in;
   logic [15:0] max_cnt_ff, max_cnt_in;
   logic [7:0]  divisor_ff, divisor_in;
   logic [23:0] period_ff, period_in;

   // ranging state
   phase_type               phase_ff, phase_in;
   logic [23:0]             us_ff, us_in;
   logic [7:0]              pc_ff, pc_in;
   logic [COUNT_WIDTH-1:0]  ec_ff, ec_in;

   // beat sequencer
   seq_type                 seq_ff, seq_in;
   logic                    echo_ff, echo_in;
   logic                    trig_ff, trig_in;
   logic                    rvalid_ff, rvalid_in;
   status_type              status_ff, status_in;
   logic [15:0]             dist_ff, dist_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [URC_RSP_WIDTH-1:0] rsp_data_ff, rsp_data_in;

   // tick evaluation results
   phase_type               ev_phase;
   logic [23:0]             ev_us;
   logic [7:0]              ev_pc;
   logic [COUNT_WIDTH-1:0]  ev_ec;
   logic                    ev_trig;
   logic                    ev_valid;
   status_type              ev_status;
   logic                    ev_div;
   logic [COUNT_WIDTH-1:0]  ev_dividend;
   presc_type               ps;

   logic                    div_start;
   logic                    div_done;
   logic [COUNT_WIDTH-1:0]  quotient;
   logic [CMP_W-1:0]        quot_wide;
   logic                    in_beat;
   logic                    out_free;

   assign csr_ready  = 1'b1;
   assign req_tready = (seq_ff == SEQ_READY);
   assign in_beat    = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign quot_wide  = {16'd0, quotient};

   // register writes, unknown indexes dropped
   always_comb begin
      lead_in     = lead_ff;
      width_in    = width_ff;
      presc_in    = presc_ff;
      wait_lim_in = wait_lim_ff;
      max_cnt_in  = max_cnt_ff;
      divisor_in  = divisor_ff;
      period_in   = period_ff;
      if (csr_valid) begin
         case (csr_index)
            REG_TRIGGER_LEAD:  lead_in     = csr_data[7:0];
            REG_TRIGGER_WIDTH: width_in    = csr_data[7:0];
            REG_PRESCALE:      presc_in    = csr_data[7:0];
            REG_WAIT_LIMIT:    wait_lim_in = csr_data[15:0];
            REG_MAX_COUNT:     max_cnt_in  = csr_data[15:0];
            REG_DIVISOR:       divisor_in  = csr_data[7:0];
            REG_PERIOD:        period_in   = csr_data[23:0];
            default: ;
         endcase
      end
   end

   // one microsecond tick of the ranging sequence
   always_comb begin
      ev_phase    = phase_ff;
      ev_us       = us_ff;
      ev_pc       = pc_ff;
      ev_ec       = ec_ff;
      ev_trig     = 1'b0;
      ev_valid    = 1'b0;
      ev_status   = STATUS_OK;
      ev_div      = 1'b0;
      ev_dividend = ec_ff;
      ps          = '0;

      // corrupt phase code restarts the cycle
      unique case (ev_phase) inside
         PH_LEAD, PH_PULSE, PH_WAIT, PH_MEASURE, PH_IDLE: ;
         default: begin
            ev_phase = PH_LEAD;
            ev_us    = '0;
            ev_pc    = '0;
            ev_ec    = '0;
         end
      endcase

      // trigger held low; a finished lead falls into the pulse this tick
      if (ev_phase == PH_LEAD) begin
         if (ev_us < {16'd0, lead_ff}) begin
            ev_us = ev_us + 24'd1;
         end else begin
            ev_phase = PH_PULSE;
            ev_us    = '0;
            ev_pc    = '0;
            ev_ec    = '0;
         end
      end

      if (ev_phase == PH_PULSE) begin
         ev_trig = 1'b1;
         ev_us   = ev_us + 24'd1;
         if (ev_us >= {16'd0, at_least_one8(width_ff)}) begin
            ev_phase = PH_WAIT;
            ev_us    = '0;
            ev_pc    = '0;
            ev_ec    = '0;
         end
      end else if (ev_phase == PH_WAIT) begin
         if (echo_ff) begin
            // rising tick is the first measured one
            ev_phase = PH_MEASURE;
            ev_us    = '0;
            ev_pc    = '0;
            ev_ec    = '0;
         end else begin
            ps    = presc_step(ev_pc, presc_ff);
            ev_pc = ps.count;
            if (ps.tick) begin
               ev_ec = ev_ec + COUNT_WIDTH'(1);
               if ({16'd0, ev_ec} >= {{COUNT_WIDTH{1'b0}}, wait_lim_ff} || ev_ec == '0) begin
                  ev_valid  = 1'b1;
                  ev_status = STATUS_NO_ECHO;
                  ev_phase  = PH_IDLE;
                  ev_us     = '0;
                  ev_pc     = '0;
                  ev_ec     = '0;
               end
            end
         end
      end else if (ev_phase == PH_IDLE) begin
         ev_us = ev_us + 24'd1;
         if (ev_us >= ((period_ff == 24'd0) ? 24'd1 : period_ff) || ev_us == 24'd0) begin
            ev_phase = PH_LEAD;
            ev_us    = '0;
            ev_pc    = '0;
            ev_ec    = '0;
         end
      end

      if (ev_phase == PH_MEASURE) begin
         if (echo_ff) begin
            ps    = presc_step(ev_pc, presc_ff);
            ev_pc = ps.count;
            // count saturates at all ones
            if (ps.tick && !(&ev_ec)) begin
               ev_ec = ev_ec + COUNT_WIDTH'(1);
            end
            if ({16'd0, ev_ec} >= {{COUNT_WIDTH{1'b0}}, max_cnt_ff} || (&ev_ec)) begin
               ev_valid  = 1'b1;
               ev_status = STATUS_TOO_LONG;
               ev_phase  = PH_IDLE;
               ev_us     = '0;
               ev_pc     = '0;
               ev_ec     = '0;
            end
         end else begin
            // echo fall: distance from the serial divider
            ev_valid    = 1'b1;
            ev_div      = 1'b1;
            ev_dividend = ev_ec;
            ev_phase    = PH_IDLE;
            ev_us       = '0;
            ev_pc       = '0;
            ev_ec       = '0;
         end
      end
   end

   // sequencer: take beat, evaluate tick, optional divide, hand off response
   always_comb begin
      seq_in         = seq_ff;
      echo_in        = echo_ff;
      phase_in       = phase_ff;
      us_in          = us_ff;
      pc_in          = pc_ff;
      ec_in          = ec_ff;
      trig_in        = trig_ff;
      rvalid_in      = rvalid_ff;
      status_in      = status_ff;
      dist_in        = dist_ff;
      div_start      = 1'b0;
      rsp_data_in    = rsp_data_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;

      unique case (seq_ff)
         SEQ_READY: begin
            if (in_beat) begin
               echo_in = req_tdata[0];
               seq_in  = SEQ_EVAL;
            end
         end
         SEQ_EVAL: begin
            phase_in    = ev_phase;
            us_in       = ev_us;
            pc_in       = ev_pc;
            ec_in       = ev_ec;
            trig_in     = ev_trig;
            rvalid_in   = ev_valid;
            status_in   = ev_status;
            dist_in     = '0;
            // divider loads the count held before this tick is stored
            div_start   = ev_div;
            seq_in      = ev_div ? SEQ_DIV : SEQ_DONE;
         end
         SEQ_DIV: begin
            if (div_done) begin
               dist_in = quot_wide[15:0];
               seq_in  = SEQ_DONE;
            end
         end
         SEQ_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {4'd0, dist_ff, status_ff, rvalid_ff, trig_ff};
               seq_in       = SEQ_READY;
            end
         end
         default: seq_in = SEQ_READY;
      endcase
   end

   urc_divider #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .done     (div_done),
      .dividend (ev_dividend),
      .divisor  (at_least_one8(divisor_ff)),
      .quotient (quotient)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         lead_ff      <= RST_TRIGGER_LEAD;
         width_ff     <= RST_TRIGGER_WIDTH;
         presc_ff     <= RST_PRESCALE;
         wait_lim_ff  <= RST_WAIT_LIMIT;
         max_cnt_ff   <= RST_MAX_COUNT;
         divisor_ff   <= RST_DIVISOR;
         period_ff    <= RST_PERIOD;
         phase_ff     <= PH_LEAD;
         us_ff        <= '0;
         pc_ff        <= '0;
         ec_ff        <= '0;
         seq_ff       <= SEQ_READY;
         rsp_valid_ff <= 1'b0;
      end else begin
         lead_ff      <= lead_in;
         width_ff     <= width_in;
         presc_ff     <= presc_in;
         wait_lim_ff  <= wait_lim_in;
         max_cnt_ff   <= max_cnt_in;
         divisor_ff   <= divisor_in;
         period_ff    <= period_in;
         phase_ff     <= phase_in;
         us_ff        <= us_in;
         pc_ff        <= pc_in;
         ec_ff        <= ec_in;
         seq_ff       <= seq_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      // payload
      echo_ff     <= echo_in;
      trig_ff     <= trig_in;
      rvalid_ff   <= rvalid_in;
      status_ff   <= status_in;
      dist_ff     <= dist_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire
